@@ src/aepr_pkg.sv @@
package aepr_pkg;

  localparam int unsigned DefaultMaxColumns = 4096;

  localparam logic [15:0] RstSetpoint        = 16'd600;
  localparam logic [15:0] RstTolerance       = 16'd50;
  localparam logic [15:0] RstGainQ8          = 16'd13;
  localparam logic [15:0] RstExposureLimit   = 16'd2048;
  localparam logic [11:0] RstWindowStart     = 12'd0;
  localparam logic [12:0] RstWindowLength    = 13'd1;
  localparam logic [3:0]  RstFlushFrames     = 4'd4;
  localparam logic [15:0] RstInitialExposure = 16'd0;

  typedef enum logic [2:0] {
    REG_SETPOINT         = 3'd0,
    REG_TOLERANCE        = 3'd1,
    REG_GAIN_Q8          = 3'd2,
    REG_EXPOSURE_LIMIT   = 3'd3,
    REG_WINDOW_START     = 3'd4,
    REG_WINDOW_LENGTH    = 3'd5,
    REG_FLUSH_FRAMES     = 3'd6,
    REG_INITIAL_EXPOSURE = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ADJUST  = 2'd0,
    ST_SETTLED = 2'd1,
    ST_LOW     = 2'd2,
    ST_HIGH    = 2'd3
  } status_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] setpoint;
    logic [15:0] tolerance;
    logic [15:0] gain_q8;
    logic [15:0] exposure_limit;
    logic [11:0] window_start;
    logic [12:0] window_length;
    logic [3:0]  flush_frames;
    logic [15:0] initial_exposure;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] err;
    status_t            status;
    logic [15:0]        shown;
    logic               adjust;
  } eval_t;

endpackage

@@ src/aepr_cfg_regs.sv @@
module aepr_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output aepr_pkg::cfg_t     cfg
);
  import aepr_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint         <= RstSetpoint;
      cfg_r.tolerance        <= RstTolerance;
      cfg_r.gain_q8          <= RstGainQ8;
      cfg_r.exposure_limit   <= RstExposureLimit;
      cfg_r.window_start     <= RstWindowStart;
      cfg_r.window_length    <= RstWindowLength;
      cfg_r.flush_frames     <= RstFlushFrames;
      cfg_r.initial_exposure <= RstInitialExposure;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_SETPOINT:         cfg_r.setpoint         <= wr_data;
        REG_TOLERANCE:        cfg_r.tolerance        <= wr_data;
        REG_GAIN_Q8:          cfg_r.gain_q8          <= wr_data;
        REG_EXPOSURE_LIMIT:   cfg_r.exposure_limit   <= wr_data;
        REG_WINDOW_START:     cfg_r.window_start     <= wr_data[11:0];
        REG_WINDOW_LENGTH:    cfg_r.window_length    <= wr_data[12:0];
        REG_FLUSH_FRAMES:     cfg_r.flush_frames     <= wr_data[3:0];
        REG_INITIAL_EXPOSURE: cfg_r.initial_exposure <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/aepr_window.sv @@
module aepr_window #(
  parameter int unsigned MAX_COLUMNS = aepr_pkg::DefaultMaxColumns
) (
  input  logic [11:0] column,
  input  logic [15:0] pixel_value,
  input  logic [11:0] window_start,
  input  logic [12:0] window_length,
  input  logic [15:0] peak_in,
  output logic [15:0] peak_out
);
  localparam logic [16:0] ColLimit = 17'(MAX_COLUMNS);

  logic [13:0] win_end;
  logic        in_window;

  assign win_end   = 14'(window_start) + 14'(window_length);
  // Keep the larger of the running peak and an in-window pixel
  assign in_window = (17'(column) < ColLimit) && (column >= window_start) &&
                     (14'(column) < win_end);
  assign peak_out  = (in_window && (pixel_value > peak_in)) ? pixel_value : peak_in;

endmodule

@@ src/aepr_eval.sv @@
module aepr_eval (
  input  aepr_pkg::cfg_t  cfg,
  input  logic [15:0]     cur_exposure,
  input  logic [15:0]     peak,
  output aepr_pkg::eval_t res
);
  import aepr_pkg::*;

  logic signed [16:0] err;
  logic [15:0]        mag;
  logic signed [33:0] prod;
  logic signed [33:0] num;
  logic signed [25:0] quo;
  logic signed [25:0] next_exp;
  logic               neg;
  logic               over_full;
  logic               above_limit;
  logic               out_of_tol;

  assign err  = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, peak});
  assign mag  = err[16] ? 16'(-err) : err[15:0];
  assign out_of_tol = mag > cfg.tolerance;

  assign prod = $signed({18'd0, cfg.gain_q8}) * 34'(err);
  assign num  = $signed({10'd0, cur_exposure, 8'd0}) + prod;
  // Divide by 256 truncating toward zero
  assign quo  = 26'(num >>> 8);
  assign next_exp = quo + 26'((num[33] && (num[7:0] != 8'd0)) ? 1 : 0);

  assign neg         = next_exp[25];
  assign over_full   = !neg && (next_exp[24:16] != 9'd0);
  assign above_limit = !neg && (over_full || (next_exp[15:0] > cfg.exposure_limit));

  always_comb begin
    res.err    = err;
    res.adjust = 1'b0;
    if (out_of_tol) begin
      if (neg) begin
        res.status = ST_LOW;
        res.shown  = 16'd0;
      end else begin
        res.shown  = over_full ? 16'hFFFF : next_exp[15:0];
        res.status = above_limit ? ST_HIGH : ST_ADJUST;
        res.adjust = !above_limit;
      end
    end else begin
      res.shown  = cur_exposure;
      res.status = (cur_exposure > cfg.exposure_limit) ? ST_HIGH : ST_SETTLED;
    end
  end

endmodule

@@ src/auto_exposure_peak_regulator_core.sv @@
// Channel  | ports                  | tdata / tuser / tlast contents
// ---------+------------------------+---------------------------------------------
// in_      | tvalid tready tdata    | tdata: pixel_value[15:0] column[27:16]
//          | tuser tlast            | tuser: op (0 start, 1 pixel); tlast: frame_end
// out_     | tvalid tready tdata    | tdata: exposure[15:0] status[17:16]
//          |                        |        peak[33:18] error[50:34]
// cfg_     | valid ready index data | index 0..7, data[15:0] (narrow regs use LSBs)
//
// One transaction per cycle sustained unless the result channel stalls; each item is
// registered on input, then peak/error/exposure logic loads the result register.
// The multiply-add of the exposure update sets the critical path.
// Reset (rst_n low, synchronous) loads register defaults and returns to idle.
// A stalled result holds the pipe only while the input register is full.
// cfg_ready is always high; writes are expected while the block is idle.
module auto_exposure_peak_regulator_core #(
  parameter int unsigned MAX_COLUMNS = aepr_pkg::DefaultMaxColumns
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_value[15:0], column[27:16], zero pad
  input  logic        in_tuser,   // op[0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // exposure[15:0], status[17:16], peak[33:18],
                                  // error[50:34], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import aepr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DISCARD = 2'd1,
    PH_MEASURE = 2'd2
  } phase_t;

  cfg_t  cfg;
  eval_t ev;

  // input register
  logic        in_valid_r;
  logic        op_r;
  logic [15:0] pix_r;
  logic [11:0] col_r;
  logic        last_r;

  // regulation state
  phase_t      phase_r, phase_nxt;
  logic [15:0] cur_exp_r, cur_exp_nxt;
  logic [15:0] peak_r, peak_nxt;
  logic [3:0]  discard_r, discard_nxt;

  // result register
  logic        out_valid_r;
  logic [15:0] res_exp_r, res_exp_nxt;
  status_t     res_st_r, res_st_nxt;
  logic [15:0] res_peak_r, res_peak_nxt;
  logic [16:0] res_err_r, res_err_nxt;
  logic        has_res;

  logic        go;
  logic [15:0] peak_upd;
  logic [3:0]  discard_dec;

  assign cfg_ready = 1'b1;

  aepr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  aepr_window #(.MAX_COLUMNS(MAX_COLUMNS)) u_window (
    .column        (col_r),
    .pixel_value   (pix_r),
    .window_start  (cfg.window_start),
    .window_length (cfg.window_length),
    .peak_in       (peak_r),
    .peak_out      (peak_upd)
  );

  aepr_eval u_eval (
    .cfg          (cfg),
    .cur_exposure (cur_exp_r),
    .peak         (peak_upd),
    .res          (ev)
  );

  // Advance the held item whenever the result register is free or draining
  assign go        = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || go;
  assign discard_dec = discard_r - 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    cur_exp_nxt  = cur_exp_r;
    peak_nxt     = peak_r;
    discard_nxt  = discard_r;
    has_res      = 1'b0;
    res_exp_nxt  = ev.shown;
    res_st_nxt   = ev.status;
    res_peak_nxt = peak_upd;
    res_err_nxt  = ev.err;

    if (op_t'(op_r) == OP_START) begin
      cur_exp_nxt = cfg.initial_exposure;
      if (cfg.setpoint <= cfg.tolerance) begin
        // Already within tolerance: report right away, settled or high against the limit
        has_res      = 1'b1;
        phase_nxt    = PH_IDLE;
        peak_nxt     = 16'd0;
        discard_nxt  = 4'd0;
        res_exp_nxt  = cfg.initial_exposure;
        res_st_nxt   = (cfg.initial_exposure > cfg.exposure_limit) ? ST_HIGH : ST_SETTLED;
        res_peak_nxt = 16'd0;
        res_err_nxt  = {1'b0, cfg.setpoint};
      end else begin
        peak_nxt    = 16'd0;
        discard_nxt = cfg.flush_frames;
        phase_nxt   = (cfg.flush_frames != 4'd0) ? PH_DISCARD : PH_MEASURE;
      end
    end else begin
      unique case (phase_r)
        PH_DISCARD: begin
          if (last_r) begin
            discard_nxt = discard_dec;
            if (discard_dec == 4'd0) phase_nxt = PH_MEASURE;
          end
        end
        PH_MEASURE: begin
          peak_nxt = peak_upd;
          if (last_r) begin
            has_res     = 1'b1;
            cur_exp_nxt = ev.shown;
            if (ev.adjust) begin
              // New setting: start another flush round
              peak_nxt    = 16'd0;
              discard_nxt = cfg.flush_frames;
              phase_nxt   = (cfg.flush_frames != 4'd0) ? PH_DISCARD : PH_MEASURE;
            end else begin
              phase_nxt   = PH_IDLE;
              peak_nxt    = 16'd0;
              discard_nxt = 4'd0;
            end
          end
        end
        default: ;  // idle: drop pixels
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      cur_exp_r   <= 16'd0;
      peak_r      <= 16'd0;
      discard_r   <= 4'd0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (go) begin
        phase_r   <= phase_nxt;
        cur_exp_r <= cur_exp_nxt;
        peak_r    <= peak_nxt;
        discard_r <= discard_nxt;
      end
      if (go && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold until the next load
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= in_tuser;
      pix_r  <= in_tdata[15:0];
      col_r  <= in_tdata[27:16];
      last_r <= in_tlast;
    end
    if (go && has_res) begin
      res_exp_r  <= res_exp_nxt;
      res_st_r   <= res_st_nxt;
      res_peak_r <= res_peak_nxt;
      res_err_r  <= res_err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_err_r, res_peak_r, res_st_r, res_exp_r};

`ifndef SYNTH
  // Idle leaves no stale peak or flush count behind
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> peak_r == 16'd0 && discard_r == 4'd0)
    else $error("idle with leftover peak or flush count");

  // A flush round always has frames left to drop
  a_discard_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DISCARD |-> discard_r != 4'd0)
    else $error("discard phase with zero frames left");

  // An adjusting result keeps regulation running
  a_adjust_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go && has_res && res_st_nxt == ST_ADJUST |=> phase_r != PH_IDLE)
    else $error("adjusting result but regulation stopped");

  // Too-low outcome always reports zero exposure
  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_st_r == ST_LOW |-> res_exp_r == 16'd0)
    else $error("too-low result with nonzero exposure");
`endif

endmodule

@@ sim/auto_exposure_peak_regulator_core_test.sv @@
module auto_exposure_peak_regulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aepr_pkg::*;

  localparam int unsigned LineColumns = DefaultMaxColumns;
  localparam int          WorkTarget  = 1150;  // input transactions to send
  localparam int          DrainSpins  = 5000;  // give up on a late result after this
  localparam int          SettleSpins = 8;     // two-stage pipe plus margin

  typedef struct {
    op_t         op;
    logic [15:0] pix;
    logic [11:0] col;
    logic        last;
  } pixel_item_t;

  typedef struct {
    logic [15:0] exposure;
    status_t     status;
    logic [15:0] peak;
    logic [16:0] err;
  } readout_t;

  typedef enum logic [1:0] {
    RG_IDLE    = 2'd0,
    RG_FLUSH   = 2'd1,
    RG_MEASURE = 2'd2
  } regulation_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // pixel_value[15:0], column[27:16], zero pad
  logic        in_tuser = 1'b0; // op
  logic        in_tlast = 1'b0; // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // exposure[15:0], status[17:16], peak[33:18], error[50:34]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Pixel stream waiting for the driver, and regulator readouts still owed by the DUT.
  pixel_item_t sample_queue[$];
  readout_t    readouts_due[$];

  // Shadow of the regulator: register file plus loop state.
  cfg_t              live_cfg;
  logic [15:0]       cur_exposure;
  logic [15:0]       run_peak;
  logic [3:0]        flush_left;
  regulation_phase_t rg_phase;

  int          worked_items = 0;
  int          mismatch_count = 0;
  int          in_hold = 0;
  int          in_calm = 0;
  int          out_hold = 0;
  int          out_calm = 0;
  pixel_item_t on_bus;

  auto_exposure_peak_regulator_core #(
    .MAX_COLUMNS(LineColumns)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Mostly back-to-back, some short gaps, a few long ones, and now and then a
  // calm stretch of zero gaps.
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Regulator prediction
  // --------------------------------------------------------------------------

  task automatic go_idle();
    rg_phase   = RG_IDLE;
    run_peak   = '0;
    flush_left = '0;
  endtask

  // Reload the discard counter after every exposure setting.
  task automatic start_round();
    run_peak   = '0;
    flush_left = live_cfg.flush_frames;
    rg_phase   = (flush_left != 0) ? RG_FLUSH : RG_MEASURE;
  endtask

  task automatic advance_regulator(input pixel_item_t s);
    longint   sp, tol, err, mag, num, nxt;
    int       c, ws, wl;
    readout_t r;
    worked_items++;

    if (s.op == OP_START) begin
      cur_exposure = live_cfg.initial_exposure;
      // Setpoint already inside tolerance: done before any frame is seen.
      if (live_cfg.setpoint <= live_cfg.tolerance) begin
        r.exposure = cur_exposure;
        r.status   = (cur_exposure > live_cfg.exposure_limit) ? ST_HIGH : ST_SETTLED;
        r.peak     = '0;
        r.err      = {1'b0, live_cfg.setpoint};
        go_idle();
        readouts_due.push_back(r);
      end else begin
        start_round();
      end
      return;
    end

    if (rg_phase == RG_FLUSH) begin
      if (s.last) begin
        flush_left = flush_left - 4'd1;
        if (flush_left == 0) rg_phase = RG_MEASURE;
      end
      return;
    end
    if (rg_phase != RG_MEASURE) return;

    c  = s.col;
    ws = live_cfg.window_start;
    wl = live_cfg.window_length;
    if (c < LineColumns && c >= ws && c < ws + wl && s.pix > run_peak) run_peak = s.pix;
    if (!s.last) return;

    sp  = live_cfg.setpoint;
    tol = live_cfg.tolerance;
    err = sp - longint'(run_peak);
    mag = (err < 0) ? -err : err;
    r.peak = run_peak;
    r.err  = err[16:0];
    if (mag > tol) begin
      // Q8.8 proportional step; signed division truncates toward zero.
      num = longint'(cur_exposure) * 256 + longint'(live_cfg.gain_q8) * err;
      nxt = num / 256;
      if (nxt < 0) begin
        r.status     = ST_LOW;
        r.exposure   = '0;
        cur_exposure = '0;
        go_idle();
      end else begin
        r.exposure   = (nxt > 65535) ? 16'hFFFF : nxt[15:0];
        cur_exposure = r.exposure;
        if (nxt > longint'(live_cfg.exposure_limit)) begin
          r.status = ST_HIGH;
          go_idle();
        end else begin
          r.status = ST_ADJUST;
          start_round();
        end
      end
    end else begin
      r.exposure = cur_exposure;
      r.status   = (cur_exposure > live_cfg.exposure_limit) ? ST_HIGH : ST_SETTLED;
      go_idle();
    end
    readouts_due.push_back(r);
  endtask

  task automatic check_readout(input logic [55:0] bus);
    readout_t want;
    if (readouts_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, bus %h", bus));
      return;
    end
    want = readouts_due.pop_front();
    if (bus[15:0] !== want.exposure)
      report_mismatch($sformatf("exposure got %0d want %0d", bus[15:0], want.exposure));
    if (bus[17:16] !== want.status)
      report_mismatch($sformatf("status got %0d want %s", bus[17:16], want.status.name()));
    if (bus[33:18] !== want.peak)
      report_mismatch($sformatf("peak got %0d want %0d", bus[33:18], want.peak));
    if (bus[50:34] !== want.err)
      report_mismatch($sformatf("error got %0d want %0d",
                                $signed(bus[50:34]), $signed(want.err)));
  endtask

  // --------------------------------------------------------------------------
  // Driver: feed the pixel stream, predict on each accepted transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_regulator(on_bus);
      // Slot is free: either hold off for a gap or present the next item.
      if (!in_tvalid || in_tready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          on_bus = sample_queue.pop_front();
          in_tdata  <= {4'b0, on_bus.col, on_bus.pix};
          in_tuser  <= on_bus.op;
          in_tlast  <= on_bus.last;
          in_tvalid <= 1'b1;
          in_hold = pick_pause(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result channel at random and check each transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_readout(out_tdata);
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_hold = pick_pause(out_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_sample(input op_t op, input logic [15:0] pix, input logic [11:0] col,
                             input logic last);
    pixel_item_t s;
    s.op   = op;
    s.pix  = pix;
    s.col  = col;
    s.last = last;
    sample_queue.push_back(s);
  endtask

  task automatic push_noise();
    push_sample(($urandom_range(0, 5) == 0) ? OP_START : OP_PIXEL, 16'($urandom),
                12'($urandom), 1'($urandom));
  endtask

  // Caller is at a rising edge; each write starts there and ends on its handshake.
  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SETPOINT:         live_cfg.setpoint         = value;
      REG_TOLERANCE:        live_cfg.tolerance        = value;
      REG_GAIN_Q8:          live_cfg.gain_q8          = value;
      REG_EXPOSURE_LIMIT:   live_cfg.exposure_limit   = value;
      REG_WINDOW_START:     live_cfg.window_start     = value[11:0];
      REG_WINDOW_LENGTH:    live_cfg.window_length    = value[12:0];
      REG_FLUSH_FRAMES:     live_cfg.flush_frames     = value[3:0];
      REG_INITIAL_EXPOSURE: live_cfg.initial_exposure = value;
      default: ;
    endcase
  endtask

  // Narrow registers get junk above their width; only the low bits count.
  task automatic program_registers(input cfg_t s);
    write_register(REG_SETPOINT, s.setpoint);
    write_register(REG_TOLERANCE, s.tolerance);
    write_register(REG_GAIN_Q8, s.gain_q8);
    write_register(REG_EXPOSURE_LIMIT, s.exposure_limit);
    write_register(REG_WINDOW_START, {4'($urandom), s.window_start});
    write_register(REG_WINDOW_LENGTH, {3'($urandom), s.window_length});
    write_register(REG_FLUSH_FRAMES, {12'($urandom), s.flush_frames});
    write_register(REG_INITIAL_EXPOSURE, s.initial_exposure);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] with_extremes(input logic [15:0] typical);
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return typical;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int   r;
    s.setpoint       = with_extremes(16'($urandom_range(100, 60000)));
    s.tolerance      = with_extremes(16'($urandom_range(0, s.setpoint / 10)));
    s.gain_q8        = with_extremes(16'($urandom_range(1, 700)));
    s.exposure_limit = with_extremes(16'($urandom_range(500, 60000)));
    s.initial_exposure = with_extremes(16'($urandom_range(0, 4000)));
    s.window_start   = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 3000));
    r = $urandom_range(0, 14);
    case (r)
      0:       s.window_length = 13'd0;
      1:       s.window_length = 13'd4096;
      2:       s.window_length = 13'h1FFF;
      default: s.window_length = 13'($urandom_range(1, 1200));
    endcase
    // Keep discard counts small most of the time so results come often.
    r = $urandom_range(0, 11);
    if (r < 8)       s.flush_frames = 4'($urandom_range(0, 2));
    else if (r < 10) s.flush_frames = 4'($urandom_range(3, 7));
    else if (r < 11) s.flush_frames = 4'd15;
    else             s.flush_frames = 4'd0;
    return s;
  endfunction

  function automatic logic [11:0] window_column();
    int lo, hi;
    lo = live_cfg.window_start;
    hi = lo + int'(live_cfg.window_length) - 1;
    if (hi > 4095) hi = 4095;
    return 12'($urandom_range(hi, lo));
  endfunction

  // A column outside the search window, or -1 when the window covers the line.
  function automatic int outside_column();
    int lo, hi;
    if (live_cfg.window_length == 0) return $urandom_range(0, 4095);
    lo = live_cfg.window_start;
    hi = lo + int'(live_cfg.window_length) - 1;
    if (lo > 0 && (hi >= 4095 || $urandom_range(0, 1) == 1)) return $urandom_range(0, lo - 1);
    if (hi < 4095) return $urandom_range(hi + 1, 4095);
    return -1;
  endfunction

  // Aim the frame peak inside the tolerance band, just outside it, or anywhere.
  function automatic logic [15:0] pick_peak();
    int sp, tol, lo, hi, r;
    sp  = live_cfg.setpoint;
    tol = live_cfg.tolerance;
    r   = $urandom_range(0, 9);
    if (r < 4) begin
      lo = sp - tol;
      hi = sp + tol;
    end else if (r < 7) begin
      if ($urandom_range(0, 1) == 1) begin
        lo = sp + tol + 1;
        hi = sp + 3 * tol + 60;
      end else begin
        lo = sp - 3 * tol - 60;
        hi = sp - tol - 1;
      end
    end else if (r == 7) begin
      lo = 0;
      hi = 65535;
    end else if (r == 8) begin
      lo = 0;
      hi = 0;
    end else begin
      lo = 65535;
      hi = 65535;
    end
    if (lo < 0) lo = 0;
    if (hi < 0) hi = 0;
    if (lo > 65535) lo = 65535;
    if (hi > 65535) hi = 65535;
    if (lo > hi) hi = lo;
    return 16'($urandom_range(hi, lo));
  endfunction

  // One frame: a single pixel carries the peak inside the window, the rest sit
  // at or below it or fall outside the window with any value.
  task automatic push_frame(input logic [15:0] peak_goal);
    int          n, star, oc;
    logic [11:0] c;
    logic [15:0] v;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 4);
    star = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) push_noise();
      oc = outside_column();
      if (live_cfg.window_length != 0 &&
          (i == star || oc < 0 || $urandom_range(0, 2) == 0)) begin
        c = window_column();
        v = (i == star) ? peak_goal : 16'($urandom_range(0, peak_goal));
      end else begin
        c = 12'(oc);
        v = 16'($urandom);
      end
      push_sample(OP_PIXEL, v, c, i == n - 1);
    end
  endtask

  // Start plus enough frames for a few rounds; some runs are cut short so the
  // next start lands on a busy regulator.
  task automatic queue_regulation();
    int frames;
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) push_noise();
    push_sample(OP_START, 16'($urandom), 12'($urandom), 1'($urandom));
    frames = $urandom_range(1, 5) * (int'(live_cfg.flush_frames) + 1);
    if ($urandom_range(0, 9) == 0) frames = $urandom_range(0, frames);
    repeat (frames) push_frame(pick_peak());
  endtask

  // Wait until the stream is empty and every readout is in, then let the pipe
  // settle. Readouts that never show up are reported and dropped.
  task automatic wait_drained();
    int spins;
    spins = 0;
    while ((sample_queue.size() != 0 || in_tvalid || readouts_due.size() != 0) &&
           spins < DrainSpins) begin
      @(posedge clk);
      spins++;
    end
    repeat (SettleSpins) @(posedge clk);
    if (readouts_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", readouts_due.size()));
      readouts_due.delete();
    end
  endtask

  // Bring the regulator back to idle with frames that hit the setpoint exactly,
  // so register writes do not land mid-regulation (skipped when the window is empty).
  task automatic close_regulation();
    if (rg_phase != RG_IDLE && live_cfg.window_length != 0) begin
      repeat (20) push_sample(OP_PIXEL, live_cfg.setpoint, live_cfg.window_start, 1'b1);
      wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t s;
    live_cfg.setpoint         = RstSetpoint;
    live_cfg.tolerance        = RstTolerance;
    live_cfg.gain_q8          = RstGainQ8;
    live_cfg.exposure_limit   = RstExposureLimit;
    live_cfg.window_start     = RstWindowStart;
    live_cfg.window_length    = RstWindowLength;
    live_cfg.flush_frames     = RstFlushFrames;
    live_cfg.initial_exposure = RstInitialExposure;
    cur_exposure = '0;
    go_idle();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: ignored pixel, four discarded frames, one adjusting step,
    // then a restart while busy.
    push_sample(OP_PIXEL, 16'hFFFF, 12'hFFF, 1'b1);
    push_sample(OP_START, 16'h0000, 12'h000, 1'b0);
    push_sample(OP_PIXEL, 16'hFFFF, 12'h000, 1'b0);
    push_sample(OP_PIXEL, 16'hFFFF, 12'h000, 1'b1);
    push_sample(OP_PIXEL, 16'hFFFF, 12'hFFF, 1'b1);
    push_sample(OP_PIXEL, 16'h0000, 12'h000, 1'b1);
    push_sample(OP_PIXEL, 16'h0000, 12'h000, 1'b1);
    push_sample(OP_PIXEL, 16'hFFFF, 12'h001, 1'b0);
    push_sample(OP_PIXEL, 16'h0000, 12'h000, 1'b1);
    push_sample(OP_START, 16'hFFFF, 12'hFFF, 1'b1);
    wait_drained();
    close_regulation();

    // Setpoint inside tolerance at start, initial exposure above the limit.
    s = live_cfg;
    s.setpoint = 16'd0; s.tolerance = 16'd0; s.flush_frames = 4'd0;
    s.initial_exposure = 16'hFFFF; s.exposure_limit = 16'd0;
    program_registers(s);
    push_sample(OP_START, 16'h0000, 12'h000, 1'b0);
    wait_drained();

    // Window running past the line end, huge gain: exposure saturates high.
    s.setpoint = 16'hFFFF; s.gain_q8 = 16'hFFFF; s.exposure_limit = 16'hFFFF;
    s.window_start = 12'hFFF; s.window_length = 13'h1FFF; s.initial_exposure = 16'd0;
    program_registers(s);
    push_sample(OP_START, 16'h0000, 12'h000, 1'b0);
    push_sample(OP_PIXEL, 16'hFFFF, 12'hFFE, 1'b0);
    push_sample(OP_PIXEL, 16'h0000, 12'hFFF, 1'b1);
    wait_drained();

    // Peak far above the setpoint drives the exposure below zero.
    s.setpoint = 16'd1; s.window_start = 12'd0; s.window_length = 13'd4096;
    program_registers(s);
    push_sample(OP_START, 16'h0000, 12'h000, 1'b0);
    push_sample(OP_PIXEL, 16'hFFFF, 12'hFFF, 1'b1);
    wait_drained();

    // Empty window: peak stays zero, first step overshoots the limit.
    s.setpoint = 16'd1000; s.tolerance = 16'd10; s.gain_q8 = 16'd256;
    s.exposure_limit = 16'd1000; s.initial_exposure = 16'd100; s.window_length = 13'd0;
    program_registers(s);
    push_sample(OP_START, 16'h0000, 12'h000, 1'b0);
    push_sample(OP_PIXEL, 16'hFFFF, 12'h000, 1'b1);
    wait_drained();

    // Peak inside tolerance on the first measured frame: settled.
    s.window_length = 13'd4096; s.exposure_limit = 16'hFFFF;
    program_registers(s);
    push_sample(OP_START, 16'h0000, 12'h000, 1'b0);
    push_sample(OP_PIXEL, 16'd1010, 12'd7, 1'b1);
    wait_drained();

    // Random settings, each followed by several regulation runs.
    while (worked_items < WorkTarget) begin
      program_registers(random_settings());
      repeat ($urandom_range(4, 10)) queue_regulation();
      wait_drained();
      close_regulation();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
